// ----- design/rtfe_pkg.sv -----
// Shared types, constants and character-sequence functions for the RTF escape encoder.
`default_nettype none
package rtfe_pkg;

  localparam int APB_ADDR_W   = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int SEQ_IDX_W    = 4;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_A_LOW  = 2'd0;
  localparam logic [1:0] REG_A_HIGH = 2'd1;
  localparam logic [1:0] REG_B_LOW  = 2'd2;
  localparam logic [1:0] REG_B_HIGH = 2'd3;

  localparam logic [7:0] RST_A_LOW  = 8'd129;
  localparam logic [7:0] RST_A_HIGH = 8'd159;
  localparam logic [7:0] RST_B_LOW  = 8'd224;
  localparam logic [7:0] RST_B_HIGH = 8'd252;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    OP_ZERO,
    OP_ESC,
    OP_LINE,
    OP_PLAIN
  } op_t;

  // One classified byte: what the back end has to spell out.
  typedef struct packed {
    op_t        op;
    logic       tag;    // ESC: \lang1041 first, LINE/PLAIN: \lang17 first
    logic       space;  // PLAIN: space after the tag
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] a_low;
    logic [7:0] a_high;
    logic [7:0] b_low;
    logic [7:0] b_high;
  } lead_cfg_t;

  typedef struct packed {
    logic lang_japanese;
    logic trail_pending;
    logic prev_was_cr;
  } enc_state_t;

  function automatic logic [SEQ_IDX_W-1:0] tag_len(cmd_t c);
    logic [SEQ_IDX_W-1:0] n;
    n = '0;
    if (c.tag) begin
      n = (c.op == OP_ESC) ? SEQ_IDX_W'(9) : SEQ_IDX_W'(7);
    end
    return n;
  endfunction

  function automatic logic [SEQ_IDX_W-1:0] cmd_len(cmd_t c);
    logic [SEQ_IDX_W-1:0] n;
    n = SEQ_IDX_W'(1);
    case (c.op)
      OP_ZERO:  n = SEQ_IDX_W'(1);
      OP_ESC:   n = tag_len(c) + SEQ_IDX_W'(4);
      OP_LINE:  n = tag_len(c) + SEQ_IDX_W'(5);
      OP_PLAIN: n = tag_len(c) + SEQ_IDX_W'(c.space) + SEQ_IDX_W'(1);
      default:  n = SEQ_IDX_W'(1);
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    logic [7:0] ch;
    ch = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
    return ch;
  endfunction

  function automatic logic [7:0] jp_tag_char(logic [SEQ_IDX_W-1:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = CH_BSLASH;
      4'd1:    ch = "l";
      4'd2:    ch = "a";
      4'd3:    ch = "n";
      4'd4:    ch = "g";
      4'd5:    ch = "1";
      4'd6:    ch = "0";
      4'd7:    ch = "4";
      default: ch = "1";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] en_tag_char(logic [SEQ_IDX_W-1:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = CH_BSLASH;
      4'd1:    ch = "l";
      4'd2:    ch = "a";
      4'd3:    ch = "n";
      4'd4:    ch = "g";
      4'd5:    ch = "1";
      default: ch = "7";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] line_char(logic [SEQ_IDX_W-1:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = CH_BSLASH;
      4'd1:    ch = "l";
      4'd2:    ch = "i";
      4'd3:    ch = "n";
      default: ch = "e";
    endcase
    return ch;
  endfunction

  // Character at position i of the sequence a command expands into.
  function automatic logic [7:0] cmd_char(cmd_t c, logic [SEQ_IDX_W-1:0] i);
    logic [SEQ_IDX_W-1:0] tl;
    logic [SEQ_IDX_W-1:0] j;
    logic [7:0]           ch;
    tl = tag_len(c);
    j  = i - tl;
    ch = CH_NUL;
    if (i < tl) begin
      ch = (c.op == OP_ESC) ? jp_tag_char(i) : en_tag_char(i);
    end else begin
      case (c.op)
        OP_ZERO: ch = CH_NUL;
        OP_ESC: begin
          case (j)
            4'd0:    ch = CH_BSLASH;
            4'd1:    ch = CH_QUOTE;
            4'd2:    ch = hex_char(c.data[7:4]);
            default: ch = hex_char(c.data[3:0]);
          endcase
        end
        OP_LINE:  ch = line_char(j);
        OP_PLAIN: ch = (c.space && (j == '0)) ? CH_SPACE : c.data;
        default:  ch = CH_NUL;
      endcase
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ----- design/rtfe_ifs.sv -----
// Valid/ready channel interfaces for source bytes and emitted RTF characters.
`default_nettype none
interface rtfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface rtfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;
  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- design/rtf_byte_escape_encoder.sv -----
// Top level: APB lead-range registers, front end, command queue and back end.
//
//   channel    dir  transfer carries
//   byte_in    in   in_byte (8b source byte, zero ends the string)
//   char_out   out  out_char (8b RTF character), last_of_run (1b)
//   APB        in   lead_range_a/b low/high registers at 0x0, 0x4, 0x8, 0xC
//
// The back end emits one character per cycle while char_out is ready: a plain byte
// expands to 1 character, an escape to 4, and a language tag adds 7 or 9.
// byte_in is ready whenever the command queue has room; an LF right after CR
// is taken with no output. rst is synchronous and returns the language state,
// queue and output register to empty; registers go to their default ranges.
`default_nettype none
module rtf_byte_escape_encoder #(
  parameter int QueueDepth = rtfe_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rtfe_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  rtfe_in_if.sink                         byte_in,
  rtfe_out_if.source                      char_out
);
  import rtfe_pkg::*;

  lead_cfg_t  lead_cfg;
  enc_state_t state;
  cmd_t       push_cmd;
  cmd_t       q_cmd;
  logic       push_valid;
  logic       push_ready;
  logic       q_valid;
  logic       q_ready;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_cfg.a_low  <= RST_A_LOW;
      lead_cfg.a_high <= RST_A_HIGH;
      lead_cfg.b_low  <= RST_B_LOW;
      lead_cfg.b_high <= RST_B_HIGH;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_A_LOW:  lead_cfg.a_low  <= pwdata[7:0];
        REG_A_HIGH: lead_cfg.a_high <= pwdata[7:0];
        REG_B_LOW:  lead_cfg.b_low  <= pwdata[7:0];
        REG_B_HIGH: lead_cfg.b_high <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_A_LOW:  prdata = {24'h0, lead_cfg.a_low};
      REG_A_HIGH: prdata = {24'h0, lead_cfg.a_high};
      REG_B_LOW:  prdata = {24'h0, lead_cfg.b_low};
      REG_B_HIGH: prdata = {24'h0, lead_cfg.b_high};
      default:    prdata = '0;
    endcase
  end

  rtfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .lead_cfg   (lead_cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .state      (state)
  );

  rtfe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  rtfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .char_out (char_out)
  );

  // a pending trail byte only follows a lead byte, which switched to lang1041
  a_trail_in_japanese: assert property (@(posedge clk) disable iff (rst)
    state.trail_pending |-> state.lang_japanese)
    else $error("trail pending outside Japanese mode");

  a_trail_not_cr: assert property (@(posedge clk) disable iff (rst)
    !(state.trail_pending && state.prev_was_cr))
    else $error("trail pending and CR flag both set");

  // only the terminator expands to a NUL, and it is a one-character run
  a_nul_is_last: assert property (@(posedge clk) disable iff (rst)
    (char_out.valid && (char_out.out_char == CH_NUL)) |-> char_out.last_of_run)
    else $error("NUL character not marked last of run");

  // a CR transfer leaves the CR flag set for the next byte
  a_cr_flag: assert property (@(posedge clk) disable iff (rst)
    (byte_in.valid && byte_in.ready && (byte_in.in_byte == CH_CR) &&
     !state.trail_pending && !u_front.is_lead) |=> state.prev_was_cr)
    else $error("CR flag not set after CR");

endmodule
`default_nettype wire

// ----- design/rtfe_front.sv -----
// Front end: takes source bytes, tracks language/trail/CR state, emits commands.
`default_nettype none
module rtfe_front (
  input  logic               clk,
  input  logic               rst,
  rtfe_in_if.sink            byte_in,
  input  rtfe_pkg::lead_cfg_t lead_cfg,
  output logic               push_valid,
  input  logic               push_ready,
  output rtfe_pkg::cmd_t     push_cmd,
  output rtfe_pkg::enc_state_t state
);
  import rtfe_pkg::*;

  enc_state_t state_next;
  logic       emit;
  logic       is_lead;
  logic       accept;
  logic [7:0] b;

  assign b       = byte_in.in_byte;
  assign is_lead = ((b >= lead_cfg.a_low) && (b <= lead_cfg.a_high)) ||
                   ((b >= lead_cfg.b_low) && (b <= lead_cfg.b_high));

  always_comb begin
    state_next     = state;
    emit           = 1'b1;
    push_cmd.op    = OP_PLAIN;
    push_cmd.tag   = 1'b0;
    push_cmd.space = 1'b0;
    push_cmd.data  = b;
    if (b == CH_NUL) begin
      push_cmd.op = OP_ZERO;
      state_next  = '0;
    end else if (state.trail_pending) begin
      push_cmd.op              = OP_ESC;
      state_next.trail_pending = 1'b0;
      state_next.prev_was_cr   = 1'b0;
    end else if (is_lead) begin
      push_cmd.op              = OP_ESC;
      push_cmd.tag             = !state.lang_japanese;
      state_next.lang_japanese = 1'b1;
      state_next.trail_pending = 1'b1;
      state_next.prev_was_cr   = 1'b0;
    end else if ((b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_BSLASH)) begin
      push_cmd.op              = OP_ESC;
      push_cmd.tag             = !state.lang_japanese;
      state_next.lang_japanese = 1'b1;
      state_next.prev_was_cr   = 1'b0;
    end else if ((b == CH_CR) || (b == CH_LF)) begin
      if ((b == CH_LF) && state.prev_was_cr) begin
        // CR already gave the \line
        emit                   = 1'b0;
        state_next.prev_was_cr = 1'b0;
      end else begin
        push_cmd.op              = OP_LINE;
        push_cmd.tag             = state.lang_japanese;
        state_next.lang_japanese = 1'b0;
        state_next.prev_was_cr   = (b == CH_CR);
      end
    end else begin
      push_cmd.tag             = state.lang_japanese;
      push_cmd.space           = state.lang_japanese && (b != CH_SPACE);
      state_next.lang_japanese = 1'b0;
      state_next.prev_was_cr   = 1'b0;
    end
  end

  assign byte_in.ready = push_ready;
  assign accept        = byte_in.valid && push_ready;
  assign push_valid    = byte_in.valid && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/rtfe_fifo.sv -----
// Small register queue of commands between front and back ends.
`default_nettype none
module rtfe_fifo #(
  parameter int Depth = rtfe_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  rtfe_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output rtfe_pkg::cmd_t rd_data
);
  import rtfe_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign wr_ready = (count != CntW'(Depth));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/rtfe_back.sv -----
// Back end: spells each command out one character per cycle, when char_out is ready, into an output register.
`default_nettype none
module rtfe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  rtfe_pkg::cmd_t q_cmd,
  rtfe_out_if.source     char_out
);
  import rtfe_pkg::*;

  logic [SEQ_IDX_W-1:0] idx;
  logic                 last_char;
  logic                 advance;
  logic                 out_valid;
  logic [7:0]           out_char;
  logic                 last_of_run;

  assign last_char = (idx == (cmd_len(q_cmd) - SEQ_IDX_W'(1)));
  assign advance   = !out_valid || char_out.ready;
  assign q_ready   = advance && last_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      out_valid <= q_valid;
      if (q_valid) begin
        idx <= last_char ? '0 : idx + SEQ_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_valid) begin
      out_char    <= cmd_char(q_cmd, idx);
      last_of_run <= last_char;
    end
  end

  assign char_out.valid       = out_valid;
  assign char_out.out_char    = out_char;
  assign char_out.last_of_run = last_of_run;

endmodule
`default_nettype wire
